// ===== src/pitot_pkg.sv =====
// Package for the pitot-tube airspeed block: field widths, item structs,
// status codes and configuration register indexes. No dependencies.
package pitot_pkg;

    // Field widths of the input and result items.
    localparam int VOLT_W    = 13;
    localparam int DENS_W    = 12;
    localparam int PRES_W    = 16;
    localparam int SPEED_W   = 20;
    localparam int STAT_W    = 2;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    // Datapath widths: the pressure numerator is a 13-bit difference times 1000,
    // the speed numerator is the pressure shifted up by 27 places.
    localparam int KPA_W        = 10;
    localparam int NUM1_W       = VOLT_W + KPA_W;
    localparam int SPEED_SHIFT  = 27;
    localparam int NUM2_W       = PRES_W + SPEED_SHIFT;
    localparam int ROOT_W       = (NUM2_W + 1) / 2;

    localparam logic [KPA_W-1:0] PA_PER_KPA = 10'd1000;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] OFFSET_RESET = 13'd2500;
    localparam logic [CFG_W-1:0] SENS_RESET   = 13'd1000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SENS   = 2'd1;

    // Status codes.
    localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_PRES_SAT   = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_DENS_ZERO  = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_SPEED_SAT  = 2'd3;

    typedef struct packed {
        logic [VOLT_W-1:0] voltage_mv;
        logic [DENS_W-1:0] air_density;
    } sample_t;

    typedef struct packed {
        logic [PRES_W-1:0]  pressure_pa;
        logic [SPEED_W-1:0] air_speed;
        logic [STAT_W-1:0]  status;
    } result_t;

endpackage

// ===== src/pitot_div_cell.sv =====
// One cell of a restoring divider row: one quotient bit per cell.
// Standalone; numerator and quotient share one shift register.
module pitot_div_cell #(
    parameter int NUM_W  = 23,
    parameter int DEN_W  = 13,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [DEN_W-1:0]  in_rem,
    input  logic [NUM_W-1:0]  in_nq,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [DEN_W-1:0]  out_rem,
    output logic [NUM_W-1:0]  out_nq,
    output logic [DEN_W-1:0]  out_den,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  nq_reg, nq_next;
    logic [DEN_W-1:0]  den_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    // Bring down the next numerator bit and try to subtract the divisor.
    always_comb
    begin
        trial    = {in_rem, in_nq[NUM_W-1]};
        ge       = (trial >= {1'b0, in_den});
        diff     = trial - {1'b0, in_den};
        rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq_next  = {in_nq[NUM_W-2:0], ge};
    end

    // The valid flag is control state; the payload needs no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        nq_reg   <= nq_next;
        den_reg  <= in_den;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_nq    = nq_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

// ===== src/pitot_sqrt_cell.sv =====
// One cell of a digit-by-digit square root row: one root bit per cell.
// Standalone; the radicand shifts out two bits per cell.
module pitot_sqrt_cell #(
    parameter int ROOT_W = 22,
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [ROOT_W:0]     in_rem,
    input  logic [ROOT_W-1:0]   in_root,
    input  logic [2*ROOT_W-1:0] in_rad,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [ROOT_W:0]     out_rem,
    output logic [ROOT_W-1:0]   out_root,
    output logic [2*ROOT_W-1:0] out_rad,
    output logic [SIDE_W-1:0]   out_side
);

    logic                valid_reg;
    logic [ROOT_W:0]     rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [2*ROOT_W-1:0] rad_reg, rad_next;
    logic [SIDE_W-1:0]   side_reg;
    logic [ROOT_W+2:0]   trial;
    logic [ROOT_W+2:0]   test;
    logic [ROOT_W+2:0]   diff;
    logic                ge;

    // Bring down two radicand bits and try to subtract 4*root + 1.
    always_comb
    begin
        trial     = {in_rem, in_rad[2*ROOT_W-1 -: 2]};
        test      = {1'b0, in_root, 2'b01};
        ge        = (trial >= test);
        diff      = trial - test;
        rem_next  = ge ? diff[ROOT_W:0] : trial[ROOT_W:0];
        root_next = {in_root[ROOT_W-2:0], ge};
        rad_next  = {in_rad[2*ROOT_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        rad_reg  <= rad_next;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_rad   = rad_reg;
    assign out_side  = side_reg;

endmodule

// ===== src/pitot_pressure_to_airspeed_top.sv =====
// Top level of the pitot-tube airspeed block: configuration registers, input
// stage, two divider rows, a square root row and the result register.
// Depends on pitot_pkg, pitot_div_cell and pitot_sqrt_cell.

// A new item is taken in every clock cycle (busy stays low). Its result is on
// result with done high once the item has passed every register in the path,
// and results keep their order. The path holds 90 registers: one input stage,
// 23 cells for the pressure division, 43 cells for the division by density,
// 22 cells for the square root, and the result register. Results are shown
// for one cycle only; the receiver must take them as they come.
// Configuration writes are always taken (cfg_ready is high) and act on items
// accepted after the write.
module pitot_pressure_to_airspeed_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  pitot_pkg::sample_t                    sample,
    output logic                                  done,
    output pitot_pkg::result_t                    result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pitot_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pitot_pkg::CFG_W-1:0]           cfg_data
);

    import pitot_pkg::*;

    localparam int SIDE1_W = DENS_W + 1;
    localparam int SIDE2_W = PRES_W + 2;
    localparam int LATENCY = 1 + NUM1_W + NUM2_W + ROOT_W + 1;

    // Configuration registers.
    logic [CFG_W-1:0] offset_reg, offset_next;
    logic [CFG_W-1:0] sens_reg, sens_next;

    // Input stage.
    logic              s0_valid_reg;
    logic [NUM1_W-1:0] s0_num_reg, s0_num_next;
    logic [CFG_W-1:0]  s0_sens_reg;
    logic [DENS_W-1:0] s0_dens_reg;
    logic              s0_nz_reg, s0_nz_next;
    logic [VOLT_W-1:0] diff_mv;

    // Pressure division row.
    logic              d1_valid [0:NUM1_W];
    logic [CFG_W-1:0]  d1_rem   [0:NUM1_W];
    logic [NUM1_W-1:0] d1_nq    [0:NUM1_W];
    logic [CFG_W-1:0]  d1_den   [0:NUM1_W];
    logic [SIDE1_W-1:0] d1_side [0:NUM1_W];

    // Division by density row.
    logic              d2_valid [0:NUM2_W];
    logic [DENS_W-1:0] d2_rem   [0:NUM2_W];
    logic [NUM2_W-1:0] d2_nq    [0:NUM2_W];
    logic [DENS_W-1:0] d2_den   [0:NUM2_W];
    logic [SIDE2_W-1:0] d2_side [0:NUM2_W];

    // Square root row.
    logic                sq_valid [0:ROOT_W];
    logic [ROOT_W:0]     sq_rem   [0:ROOT_W];
    logic [ROOT_W-1:0]   sq_root  [0:ROOT_W];
    logic [2*ROOT_W-1:0] sq_rad   [0:ROOT_W];
    logic [SIDE2_W-1:0]  sq_side  [0:ROOT_W];

    // Pressure formed between the two division rows.
    logic [NUM1_W-1:0] q1;
    logic              q1_nz;
    logic [DENS_W-1:0] q1_dens;
    logic              p_over;
    logic [PRES_W-1:0] p_val;
    logic              p_sat;

    // Result register.
    logic              done_reg;
    result_t           result_reg, result_next;
    logic [PRES_W-1:0] f_pres;
    logic              f_psat;
    logic              f_dzero;
    logic [ROOT_W-1:0] f_root;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Register write decoder.
    always_comb
    begin
        offset_next = offset_reg;
        sens_next   = sens_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IDX_OFFSET: offset_next = cfg_data;
                CFG_IDX_SENS:   sens_next   = cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RESET;
            sens_reg   <= SENS_RESET;
        end
        else
        begin
            offset_reg <= offset_next;
            sens_reg   <= sens_next;
        end
    end

    // Input stage: voltage above offset, scaled to pascals times sensitivity.
    always_comb
    begin
        diff_mv     = sample.voltage_mv - offset_reg;
        s0_nz_next  = (sample.voltage_mv > offset_reg);
        s0_num_next = s0_nz_next ? NUM1_W'(diff_mv) * NUM1_W'(PA_PER_KPA) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_num_reg  <= s0_num_next;
        s0_sens_reg <= sens_reg;
        s0_dens_reg <= sample.air_density;
        s0_nz_reg   <= s0_nz_next;
    end

    // Pressure division: numerator over sensitivity.
    assign d1_valid[0] = s0_valid_reg;
    assign d1_rem[0]   = '0;
    assign d1_nq[0]    = s0_num_reg;
    assign d1_den[0]   = s0_sens_reg;
    assign d1_side[0]  = {s0_dens_reg, s0_nz_reg};

    for (genvar i = 0; i < NUM1_W; i++)
    begin : g_div1
        pitot_div_cell #(
            .NUM_W  (NUM1_W),
            .DEN_W  (CFG_W),
            .SIDE_W (SIDE1_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (d1_valid[i]),
            .in_rem    (d1_rem[i]),
            .in_nq     (d1_nq[i]),
            .in_den    (d1_den[i]),
            .in_side   (d1_side[i]),
            .out_valid (d1_valid[i+1]),
            .out_rem   (d1_rem[i+1]),
            .out_nq    (d1_nq[i+1]),
            .out_den   (d1_den[i+1]),
            .out_side  (d1_side[i+1])
        );
    end

    // Pressure clamp and saturation. A zero numerator gives zero pressure even
    // when the sensitivity is zero.
    always_comb
    begin
        q1      = d1_nq[NUM1_W];
        q1_nz   = d1_side[NUM1_W][0];
        q1_dens = d1_side[NUM1_W][SIDE1_W-1:1];
        p_over  = |q1[NUM1_W-1:PRES_W];
        p_sat   = q1_nz && p_over;
        if (!q1_nz)
        begin
            p_val = '0;
        end
        else if (p_over)
        begin
            p_val = '1;
        end
        else
        begin
            p_val = q1[PRES_W-1:0];
        end
    end

    // Division of the shifted pressure by density.
    assign d2_valid[0] = d1_valid[NUM1_W];
    assign d2_rem[0]   = '0;
    assign d2_nq[0]    = {p_val, {SPEED_SHIFT{1'b0}}};
    assign d2_den[0]   = q1_dens;
    assign d2_side[0]  = {p_val, p_sat, (q1_dens == '0)};

    for (genvar i = 0; i < NUM2_W; i++)
    begin : g_div2
        pitot_div_cell #(
            .NUM_W  (NUM2_W),
            .DEN_W  (DENS_W),
            .SIDE_W (SIDE2_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (d2_valid[i]),
            .in_rem    (d2_rem[i]),
            .in_nq     (d2_nq[i]),
            .in_den    (d2_den[i]),
            .in_side   (d2_side[i]),
            .out_valid (d2_valid[i+1]),
            .out_rem   (d2_rem[i+1]),
            .out_nq    (d2_nq[i+1]),
            .out_den   (d2_den[i+1]),
            .out_side  (d2_side[i+1])
        );
    end

    // Square root of the quotient.
    assign sq_valid[0] = d2_valid[NUM2_W];
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_rad[0]   = (2*ROOT_W)'(d2_nq[NUM2_W]);
    assign sq_side[0]  = d2_side[NUM2_W];

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        pitot_sqrt_cell #(
            .ROOT_W (ROOT_W),
            .SIDE_W (SIDE2_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[i]),
            .in_rem    (sq_rem[i]),
            .in_root   (sq_root[i]),
            .in_rad    (sq_rad[i]),
            .in_side   (sq_side[i]),
            .out_valid (sq_valid[i+1]),
            .out_rem   (sq_rem[i+1]),
            .out_root  (sq_root[i+1]),
            .out_rad   (sq_rad[i+1]),
            .out_side  (sq_side[i+1])
        );
    end

    // Speed saturation and status priority: zero density, then speed
    // saturated, then pressure saturated.
    always_comb
    begin
        f_root  = sq_root[ROOT_W];
        f_pres  = sq_side[ROOT_W][SIDE2_W-1:2];
        f_psat  = sq_side[ROOT_W][1];
        f_dzero = sq_side[ROOT_W][0];
        result_next.pressure_pa = f_pres;
        if (f_dzero)
        begin
            result_next.air_speed = '0;
            result_next.status    = STATUS_DENS_ZERO;
        end
        else if (|f_root[ROOT_W-1:SPEED_W])
        begin
            result_next.air_speed = '1;
            result_next.status    = STATUS_SPEED_SAT;
        end
        else
        begin
            result_next.air_speed = f_root[SPEED_W-1:0];
            result_next.status    = f_psat ? STATUS_PRES_SAT : STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sq_valid[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every accepted item comes out after the fixed latency, and nothing else.
    a_latency_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted item did not produce a result on time");

    a_latency_in: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching accepted item");

    a_dens_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STATUS_DENS_ZERO) |-> (result.air_speed == '0))
        else $error("zero density result carries a non-zero speed");

    a_speed_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STATUS_SPEED_SAT) |-> (result.air_speed == '1))
        else $error("saturated speed is not at full scale");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for pitot_pressure_to_airspeed_top: drives samples and
// register writes, predicts each reading and checks every result strobe.
// Depends on pitot_pkg and the RTL of the block.
`timescale 1ns / 100ps

// Holds the register copy and the queue of predicted readings.
class airspeed_scoreboard;

    localparam logic [63:0] PRESSURE_CEILING = (64'd1 << pitot_pkg::PRES_W) - 1;
    localparam logic [63:0] SPEED_CEILING    = (64'd1 << pitot_pkg::SPEED_W) - 1;

    logic [pitot_pkg::CFG_W-1:0] offset_mv;
    logic [pitot_pkg::CFG_W-1:0] sensitivity;
    pitot_pkg::result_t          expected_readings[$];
    int                          mismatch_count;

    function new();
        offset_mv      = pitot_pkg::OFFSET_RESET;
        sensitivity    = pitot_pkg::SENS_RESET;
        mismatch_count = 0;
    endfunction

    // Mirrors a register write; spare indexes have no register behind them.
    function void write_register(logic [pitot_pkg::CFG_IDX_W-1:0] index,
                                 logic [pitot_pkg::CFG_W-1:0] data);
        if (index == pitot_pkg::CFG_IDX_OFFSET)
            offset_mv = data;
        else if (index == pitot_pkg::CFG_IDX_SENS)
            sensitivity = data;
    endfunction

    // Pressure from the sensor voltage, then speed from pressure and density.
    function pitot_pkg::result_t airspeed_of(pitot_pkg::sample_t s);
        logic [63:0]        pressure;
        logic [63:0]        quotient;
        logic [63:0]        root;
        logic [63:0]        trial;
        logic               pressure_sat;
        pitot_pkg::result_t r;
        pressure     = '0;
        pressure_sat = 1'b0;
        if (s.voltage_mv > offset_mv)
        begin
            if (sensitivity == '0)
            begin
                pressure     = PRESSURE_CEILING;
                pressure_sat = 1'b1;
            end
            else
            begin
                pressure = (64'(s.voltage_mv) - 64'(offset_mv))
                         * 64'(pitot_pkg::PA_PER_KPA) / 64'(sensitivity);
                if (pressure > PRESSURE_CEILING)
                begin
                    pressure     = PRESSURE_CEILING;
                    pressure_sat = 1'b1;
                end
            end
        end
        r.pressure_pa = pressure[pitot_pkg::PRES_W-1:0];
        r.air_speed   = '0;
        r.status      = pitot_pkg::STATUS_OK;
        if (s.air_density == '0)
        begin
            r.status = pitot_pkg::STATUS_DENS_ZERO;
        end
        else
        begin
            quotient = (pressure << pitot_pkg::SPEED_SHIFT) / 64'(s.air_density);
            // Floor of the square root, one result bit at a time.
            root = '0;
            for (int b = 31; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= quotient)
                    root = trial;
            end
            if (root > SPEED_CEILING)
            begin
                r.air_speed = SPEED_CEILING[pitot_pkg::SPEED_W-1:0];
                r.status    = pitot_pkg::STATUS_SPEED_SAT;
            end
            else
            begin
                r.air_speed = root[pitot_pkg::SPEED_W-1:0];
                if (pressure_sat)
                    r.status = pitot_pkg::STATUS_PRES_SAT;
            end
        end
        return r;
    endfunction

    function void note_sample(pitot_pkg::sample_t s);
        expected_readings.push_back(airspeed_of(s));
    endfunction

    function int pending();
        return expected_readings.size();
    endfunction

    // Compares one result strobe with the oldest predicted reading.
    function void check_result(pitot_pkg::result_t actual);
        pitot_pkg::result_t want;
        if (expected_readings.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: unexpected reading: expected none, %s", $time,
                     $sformatf("got pressure %0d speed %0d status %0d",
                               actual.pressure_pa, actual.air_speed, actual.status));
            return;
        end
        want = expected_readings.pop_front();
        if (actual.pressure_pa !== want.pressure_pa || actual.air_speed !== want.air_speed
            || actual.status !== want.status)
        begin
            mismatch_count++;
            $display("%0t: reading mismatch: expected pressure %0d speed %0d status %0d, %s",
                     $time, want.pressure_pa, want.air_speed, want.status,
                     $sformatf("got pressure %0d speed %0d status %0d",
                               actual.pressure_pa, actual.air_speed, actual.status));
        end
    endfunction

endclass

module testbench;

    import pitot_pkg::*;

    // Indexes that decode to no register.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

    localparam int RESULT_LATENCY   = 90;
    localparam int PHASES           = 9;
    localparam int RANDOM_PER_PHASE = 190;
    localparam int VOLT_TOP         = (1 << VOLT_W) - 1;
    localparam int DENS_TOP         = (1 << DENS_W) - 1;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    sample_t              sample    = '0;
    logic                 done;
    result_t              result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    airspeed_scoreboard sb;

    pitot_pressure_to_airspeed_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .sample    (sample),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Results are shown for one cycle only, so every strobe is taken.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(result);
    end

    // Offers one item and holds it until the block takes it.
    task automatic send_sample(int volt, int dens);
        sample_t s;
        s.voltage_mv  = volt[VOLT_W-1:0];
        s.air_density = dens[DENS_W-1:0];
        start  <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_sample(s);
    endtask

    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.write_register(index, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int         phase;
        int         sent;
        int         burst;
        int         roll;
        int         volt;
        int         dens;
        bit         quiet;
        logic [CFG_W-1:0] next_offset;
        logic [CFG_W-1:0] next_sens;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (phase = 0; phase < PHASES; phase++)
        begin
            // Phase zero runs on the reset values; the others load a setting.
            case (phase)
                1: begin next_offset = 13'd0;    next_sens = 13'd1;    end
                2: begin next_offset = 13'd6144; next_sens = 13'd5000; end
                3: begin next_offset = 13'd100;  next_sens = 13'd0;    end
                4: begin next_offset = 13'd8191; next_sens = 13'd8191; end
                5: begin next_offset = 13'd1500; next_sens = 13'd37;   end
                default:
                begin
                    next_offset = 13'($urandom_range(0, 6144));
                    next_sens   = 13'($urandom_range(1, 5000));
                end
            endcase
            if (phase != 0)
            begin
                set_register(CFG_IDX_OFFSET, next_offset);
                set_register(CFG_IDX_SENS, next_sens);
                if (phase == 5)
                begin
                    set_register(CFG_IDX_SPARE_A, 13'($urandom_range(0, VOLT_TOP)));
                    set_register(CFG_IDX_SPARE_B, 13'($urandom_range(0, VOLT_TOP)));
                end
            end

            // Directed items: range edges, equal and lower voltage, zero density,
            // and the boundaries of pressure and speed saturation.
            case (phase)
                0:
                begin
                    send_sample(0, 0);
                    send_sample(2500, 1024);
                    send_sample(2501, 1024);
                    send_sample(2499, 1);
                    send_sample(6144, DENS_TOP);
                    send_sample(VOLT_TOP, DENS_TOP);
                    send_sample(VOLT_TOP, 0);
                    send_sample(VOLT_TOP, 1);
                    send_sample(3000, 1);
                    send_sample(4000, 2048);
                    send_sample(5000, 777);
                    send_sample(6000, 4094);
                end
                1:
                begin
                    send_sample(65, DENS_TOP);
                    send_sample(66, DENS_TOP);
                    send_sample(8, 1);
                    send_sample(9, 1);
                    send_sample(VOLT_TOP, 8);
                    send_sample(VOLT_TOP, 7);
                    send_sample(VOLT_TOP, 0);
                end
                3:
                begin
                    send_sample(100, 50);
                    send_sample(101, 50);
                    send_sample(101, 1);
                    send_sample(VOLT_TOP, 0);
                end
                default:
                begin
                end
            endcase

            // Random items in bursts; one phase runs with no gaps at all.
            quiet = (phase == 4);
            sent  = 0;
            while (sent < RANDOM_PER_PHASE)
            begin
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst; k++)
                begin
                    case ($urandom_range(0, 2))
                        0: volt = $urandom_range(0, VOLT_TOP);
                        1:
                        begin
                            // Close to the offset, where the clamp at zero acts.
                            volt = int'(sb.offset_mv) + int'($urandom_range(0, 240)) - 40;
                            if (volt < 0)
                                volt = 0;
                            else if (volt > VOLT_TOP)
                                volt = VOLT_TOP;
                        end
                        default: volt = $urandom_range(0, 6144);
                    endcase
                    roll = $urandom_range(0, 19);
                    if (roll < 2)
                        dens = 0;
                    else if (roll < 5)
                        dens = $urandom_range(1, 8);
                    else if (roll < 7)
                        dens = $urandom_range(DENS_TOP - 7, DENS_TOP);
                    else
                        dens = $urandom_range(0, DENS_TOP);
                    send_sample(volt, dens);
                    sent++;
                end
                if (!quiet)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 3)
                        wait_for_results();
                    else if (roll >= 35)
                        pause_sender($urandom_range(1, 6));
                end
            end

            // The registers may only change once the pipeline is empty.
            wait_for_results();
        end

        // Let any stray strobe show up before the verdict.
        repeat (RESULT_LATENCY + 30) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("pitot_pressure_to_airspeed_top regression: pass");
        else
            $display("pitot_pressure_to_airspeed_top regression: fail");
        $finish;
    end

    // Watchdog for a block that stops producing results.
    initial
    begin
        #4_000_000;
        $display("pitot_pressure_to_airspeed_top regression: fail");
        $finish;
    end

endmodule
